### rtl/core/cau_pkg.sv
// Package for the complex arithmetic unit: widths, operation codes,
// transaction structs and the front-to-back queue entry. No dependencies.
package cau_pkg;

  localparam int DW            = 16;      // data field width
  localparam int FRAC_BITS_DEF = 8;       // default Q format fraction bits
  localparam int MW            = 2 * DW;  // product / magnitude width
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                   operation;
    logic signed [DW-1:0]  a_re;
    logic signed [DW-1:0]  a_im;
    logic signed [DW-1:0]  b_re;
    logic signed [DW-1:0]  b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0]  res_re;
    logic signed [DW-1:0]  res_im;
    logic                  div_by_zero;
    logic                  saturated;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic           div;     // needs the divider
    logic           dz;      // divide by zero
    logic           neg_re;
    logic           neg_im;
    logic [MW-1:0]  mag_re;
    logic [MW-1:0]  mag_im;
    logic [MW-1:0]  den;
  } qent_t;

endpackage

### rtl/core/cau_front.sv
// Front end: registers operands and products, classifies the operation
// and forms sign/magnitude numerators. Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push,
  input  logic     full,
  output qent_t    push_data
);

  logic                 f_vld;
  op_t                  f_op;
  logic signed [DW-1:0] ar, ai, br, bi;
  logic signed [MW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb_r, p_bb_i;

  logic signed [MW:0] x_re, x_im;
  logic [MW-1:0]      m_re, m_im, den;
  logic               dz;

  assign in_ready = !f_vld || !full;
  assign push     = f_vld && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (in_ready) begin
      f_vld <= in_valid;
    end
    if (in_valid && in_ready) begin
      f_op   <= in_data.operation;
      ar     <= in_data.a_re;
      ai     <= in_data.a_im;
      br     <= in_data.b_re;
      bi     <= in_data.b_im;
      p_rr   <= in_data.a_re * in_data.b_re;
      p_ii   <= in_data.a_im * in_data.b_im;
      p_ri   <= in_data.a_re * in_data.b_im;
      p_ir   <= in_data.a_im * in_data.b_re;
      p_bb_r <= in_data.b_re * in_data.b_re;
      p_bb_i <= in_data.b_im * in_data.b_im;
    end
  end

  always_comb begin
    case (f_op)
      OP_ADD: begin
        x_re = (MW+1)'(ar) + (MW+1)'(br);
        x_im = (MW+1)'(ai) + (MW+1)'(bi);
      end
      OP_SUB: begin
        x_re = (MW+1)'(ar) - (MW+1)'(br);
        x_im = (MW+1)'(ai) - (MW+1)'(bi);
      end
      OP_MUL: begin
        x_re = (MW+1)'(p_rr) - (MW+1)'(p_ii);
        x_im = (MW+1)'(p_ri) + (MW+1)'(p_ir);
      end
      default: begin
        x_re = (MW+1)'(p_rr) + (MW+1)'(p_ii);
        x_im = (MW+1)'(p_ir) - (MW+1)'(p_ri);
      end
    endcase
    m_re = x_re[MW] ? MW'(-x_re) : x_re[MW-1:0];
    m_im = x_im[MW] ? MW'(-x_im) : x_im[MW-1:0];
    // multiply truncates the magnitude, i.e. toward zero
    if (f_op == OP_MUL) begin
      m_re = m_re >> FRAC_BITS;
      m_im = m_im >> FRAC_BITS;
    end
    den = $unsigned(p_bb_r) + $unsigned(p_bb_i);
    dz  = (f_op == OP_DIV) && (den == '0);

    push_data.div    = (f_op == OP_DIV) && !dz;
    push_data.dz     = dz;
    push_data.neg_re = x_re[MW] && !dz;
    push_data.neg_im = x_im[MW] && !dz;
    push_data.mag_re = dz ? '0 : m_re;
    push_data.mag_im = dz ? '0 : m_im;
    push_data.den    = den;
  end

endmodule

### rtl/core/cau_queue.sv
// Short register queue between front and back ends.
// Depends on cau_pkg.
module cau_queue import cau_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  qent_t             mem [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [AW:0]       cnt;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/core/cau_back.sv
// Back end: pipelined restoring divider (one quotient bit per stage),
// saturation and output register. Depends on cau_pkg.
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  qent_t     head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int RW = 3 * DW + FRAC_BITS;
  localparam logic [RW-1:0] LIM = RW'(1) << (DW - 1);

  typedef struct packed {
    logic           div;
    logic           dz;
    logic           ovf_re;
    logic           ovf_im;
    logic           neg_re;
    logic           neg_im;
    logic [RW-1:0]  rem_re;
    logic [RW-1:0]  rem_im;
    logic [DW-1:0]  q_re;
    logic [DW-1:0]  q_im;
    logic [MW-1:0]  den;
  } stg_t;

  logic          en;
  logic          vld [DW+1];
  stg_t          stg [DW+1];
  stg_t          ld;
  logic [RW-1:0] num_re, num_im, den_top;

  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;

  always_comb begin
    num_re  = RW'(head.mag_re) << FRAC_BITS;
    num_im  = RW'(head.mag_im) << FRAC_BITS;
    den_top = RW'(head.den) << DW;
    ld.div    = head.div;
    ld.dz     = head.dz;
    ld.neg_re = head.neg_re;
    ld.neg_im = head.neg_im;
    ld.den    = head.den;
    ld.q_re   = '0;
    ld.q_im   = '0;
    // a quotient of 2^DW or more saturates whatever its sign
    ld.ovf_re = head.div && (num_re >= den_top);
    ld.ovf_im = head.div && (num_im >= den_top);
    ld.rem_re = head.div ? num_re : RW'(head.mag_re);
    ld.rem_im = head.div ? num_im : RW'(head.mag_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= !empty;
    end
    if (pop) begin
      stg[0] <= ld;
    end
  end

  for (genvar s = 1; s <= DW; s++) begin : g_stage
    localparam int BI = DW - s;
    stg_t          nx;
    logic [RW-1:0] sh;
    always_comb begin
      nx = stg[s-1];
      sh = RW'(stg[s-1].den) << BI;
      if (stg[s-1].div && !stg[s-1].ovf_re && stg[s-1].rem_re >= sh) begin
        nx.rem_re   = stg[s-1].rem_re - sh;
        nx.q_re[BI] = 1'b1;
      end
      if (stg[s-1].div && !stg[s-1].ovf_im && stg[s-1].rem_im >= sh) begin
        nx.rem_im   = stg[s-1].rem_im - sh;
        nx.q_im[BI] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
      if (en) begin
        stg[s] <= nx;
      end
    end
  end

  // saturate a sign/magnitude value to DW bits
  function automatic logic [DW:0] sat_fn(input logic neg, input logic ovf,
                                          input logic [RW-1:0] m);
    logic [RW-1:0] v;
    logic          c;
    begin
      c = 1'b0;
      v = m;
      if (neg) begin
        if (ovf || m > LIM) begin
          v = LIM;
          c = 1'b1;
        end
        sat_fn = {c, DW'(-v)};
      end else begin
        if (ovf || m > LIM - 1'b1) begin
          v = LIM - 1'b1;
          c = 1'b1;
        end
        sat_fn = {c, DW'(v)};
      end
    end
  endfunction

  stg_t          fin;
  logic [RW-1:0] mf_re, mf_im;
  logic [DW:0]   sr, si;

  always_comb begin
    fin   = stg[DW];
    mf_re = fin.div ? RW'(fin.q_re) : fin.rem_re;
    mf_im = fin.div ? RW'(fin.q_im) : fin.rem_im;
    sr    = sat_fn(fin.neg_re, fin.ovf_re, mf_re);
    si    = sat_fn(fin.neg_im, fin.ovf_im, mf_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DW];
    end
    if (en) begin
      out_data.res_re      <= sr[DW-1:0];
      out_data.res_im      <= si[DW-1:0];
      out_data.div_by_zero <= fin.dz;
      out_data.saturated   <= sr[DW] || si[DW];
    end
  end

endmodule

### rtl/core/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front end, queue, back end.
// Depends on cau_pkg, cau_front, cau_queue, cau_back.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one operation per
//   transaction: op code plus operands A and B in signed Q8.8.
//   Output channel out_valid/out_ready/out_data returns one result per
//   transaction: saturated real/imaginary parts, divide-by-zero and
//   saturation flags, in input order.
//   Throughput: one transaction per cycle, sustained while out_ready
//   is high. Every operation, add included, travels the same path so
//   results stay in order. Pipeline: one front register stage
//   (products), one queue slot, a load stage, one divider stage per
//   quotient bit, and the output register. The restoring divider, one
//   quotient bit per stage, sets the pipeline depth.
//   Stalls: with out_valid high and out_ready low the back pipeline
//   holds; the queue absorbs up to four transactions and the front
//   keeps taking input until the queue and its own register are full.
//   Reset (rst, synchronous): clears all valid bits and queue pointers;
//   the block is ready on the first cycle after reset.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DEPTH     = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic  push, full, pop, empty;
  qent_t push_data, head;

  // classify and multiply
  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .full      (full),
    .push_data (push_data)
  );

  // decouples front from the stallable back pipeline
  cau_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  // divide, saturate, deliver
  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.div_by_zero) |-> (out_data.res_re == '0 && out_data.res_im == '0))
    else $error("divide by zero with nonzero result");
  a_dz_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.div_by_zero && out_data.saturated))
    else $error("divide by zero flagged as saturated");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

### tb/complex_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for complex_arithmetic_unit: random and corner-case complex add, subtract,
// multiply and divide transactions, checked against an in-bench predictor.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int FRAC      = 8;
  localparam int MAX_CYC   = 400000;
  localparam int DRAIN_CYC = 60;
  localparam int HOLD_AT   = 300;   // cycle at which the long receiver stall starts
  localparam int HOLD_LEN  = 200;

  logic      clk;
  logic      rst;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  in_item_t  pending_ops[$];   // operations waiting to be driven
  out_item_t expected_res[$];  // predicted results in issue order
  int        errors = 0;
  int        cycles = 0;
  int        send_idle_pct = 25;
  int        recv_idle_pct = 51;
  int        hold_off = 0;     // receiver long stall, cycles left
  bit        stim_done = 0;
  bit        in_ready_seen = 1'b0;  // handshake as sampled at the last rising edge

  // Clamp a wide signed value to 16 bits; flags clamping.
  function automatic logic signed [DW-1:0] clamp16(input longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[DW-1:0];
  endfunction

  // Truncate toward zero on shift and divide (not floor).
  function automatic longint shr_trunc(input longint v);
    return (v < 0) ? -((-v) >>> FRAC) : (v >>> FRAC);
  endfunction

  function automatic out_item_t complex_result(input in_item_t t);
    out_item_t r;
    longint ar, ai, br, bi, re, im, den;
    bit sat;
    ar = longint'(t.a_re); ai = longint'(t.a_im);
    br = longint'(t.b_re); bi = longint'(t.b_im);
    sat = 0;
    r.div_by_zero = 1'b0;
    case (t.operation)
      OP_ADD: begin
        re = ar + br; im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br; im = ai - bi;
      end
      OP_MUL: begin
        re = shr_trunc(ar * br - ai * bi);
        im = shr_trunc(ar * bi + ai * br);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
          re = 0; im = 0;
        end else begin
          // SV integer division truncates toward zero, as required
          re = ((ar * br + ai * bi) * (longint'(1) << FRAC)) / den;
          im = ((ai * br - ar * bi) * (longint'(1) << FRAC)) / den;
        end
      end
    endcase
    r.res_re = clamp16(re, sat);
    r.res_im = clamp16(im, sat);
    r.saturated = sat;
    return r;
  endfunction

  // Operand mix: extremes, small values and full-range noise.
  function automatic logic signed [DW-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
      3: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_op(input op_t op, input int ar, input int ai,
                          input int br, input int bi);
    in_item_t t;
    t.operation = op;
    t.a_re = DW'(ar); t.a_im = DW'(ai); t.b_re = DW'(br); t.b_im = DW'(bi);
    pending_ops.push_back(t);
  endtask

  // Driver: inputs move on the falling edge only.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= pending_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input handshake sampling and prediction.
  always @(posedge clk) begin
    in_ready_seen <= 1'b0;
    if (!rst && in_valid && in_ready) begin
      in_ready_seen <= 1'b1;
      expected_res.push_back(complex_result(in_data));
    end
  end

  // Receiver ready, with one long hold-off started and counted here.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (cycles == HOLD_AT) begin
      hold_off  <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (out_data.res_re !== want.res_re)
          $display("%0t: res_re exp %0d got %0d", $time, want.res_re, out_data.res_re);
        if (out_data.res_im !== want.res_im)
          $display("%0t: res_im exp %0d got %0d", $time, want.res_im, out_data.res_im);
        if (out_data.div_by_zero !== want.div_by_zero)
          $display("%0t: div_by_zero exp %b got %b", $time, want.div_by_zero,
                   out_data.div_by_zero);
        if (out_data.saturated !== want.saturated)
          $display("%0t: saturated exp %b got %b", $time, want.saturated,
                   out_data.saturated);
        if (out_data !== want) errors++;
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Wait until every queued transaction was taken.
  task automatic wait_sent();
    while (pending_ops.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    in_item_t t;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: each op at the extremes, zero divisor, rounding signs.
    queue_op(OP_ADD, 32767, -32768, 32767, -32768);
    queue_op(OP_ADD, 1, -1, -1, 1);
    queue_op(OP_SUB, -32768, 32767, 32767, -32768);
    queue_op(OP_SUB, 0, 0, -32768, -32768);
    queue_op(OP_MUL, -32768, -32768, -32768, -32768);
    queue_op(OP_MUL, 32767, 32767, 32767, -32768);
    queue_op(OP_MUL, -1, 0, 1, 0);
    queue_op(OP_MUL, 256, 256, 256, -256);
    queue_op(OP_DIV, 256, 256, 0, 0);
    queue_op(OP_DIV, 0, 0, 0, 0);
    queue_op(OP_DIV, 32767, -32768, 1, 0);
    queue_op(OP_DIV, -32768, -32768, 0, 1);
    queue_op(OP_DIV, -1, 1, 3, 0);
    queue_op(OP_DIV, 1, 0, 32767, -32768);
    queue_op(OP_DIV, 256, 512, 256, 256);
    queue_op(OP_DIV, -32768, 0, -32768, -32768);
    queue_op(OP_SUB, 12345, -6789, -4321, 999);

    // Random, three idling phases; the long receiver stall lands in the first.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 51; recv_idle_pct = 25;
      end else if (ph == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 345; n++) begin
        t.operation = op_t'($urandom_range(0, 3));
        t.a_re = pick_operand(); t.a_im = pick_operand();
        t.b_re = pick_operand(); t.b_im = pick_operand();
        pending_ops.push_back(t);
      end
      wait_sent();
    end

    while (expected_res.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
